// ----- src/tspg_pkg.sv -----
package tspg_pkg;

	localparam int TARGET_BITS = 31;
	localparam int POSITION_BITS_DEF = 31;
	localparam int AXES = 3;
	localparam int PERIOD_BITS = 16;
	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd700;
	localparam int S_DATA_BITS = 96;
	localparam int M_DATA_BITS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// bit 0 upward: step x/y/z, dir x/y/z, busy, done, accepted
	typedef struct packed {
		logic       accepted;
		logic       done;
		logic       busy;
		logic [2:0] dir;
		logic [2:0] step;
	} result_t;

endpackage

// ----- src/tspg_front.sv -----
module tspg_front #(
	parameter int POSITION_BITS = tspg_pkg::POSITION_BITS_DEF,
	localparam int ITEM_BITS = tspg_pkg::AXES * POSITION_BITS + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tspg_pkg::S_DATA_BITS-1:0] in_data,
	input  logic                             in_kind,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ITEM_BITS-1:0]             out_item
);

	logic                 valid_s1;
	logic [ITEM_BITS-1:0] item_s1;
	logic [ITEM_BITS-1:0] item_d;

	always_comb begin
		logic signed [tspg_pkg::TARGET_BITS-1:0] tgt;
		logic signed [POSITION_BITS-1:0]         ext;
		item_d = '0;
		for (int a = 0; a < tspg_pkg::AXES; a++) begin
			tgt = in_data[a*tspg_pkg::TARGET_BITS +: tspg_pkg::TARGET_BITS];
			ext = POSITION_BITS'(tgt);
			item_d[a*POSITION_BITS +: POSITION_BITS] = ext;
		end
		item_d[ITEM_BITS-1] = (in_kind == tspg_pkg::KIND_MOVE);
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ----- src/tspg_queue.sv -----
module tspg_queue #(
	parameter int WIDTH = 94
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PTR_BITS = $clog2(tspg_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(tspg_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(tspg_pkg::QUEUE_DEPTH);
	localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(tspg_pkg::QUEUE_DEPTH - 1);

	logic [WIDTH-1:0]    mem_q [tspg_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                push;
	logic                pop;

	assign in_ready  = (count_q != FULL);
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// ----- src/tspg_back.sv -----
module tspg_back #(
	parameter int POSITION_BITS = tspg_pkg::POSITION_BITS_DEF,
	localparam int ITEM_BITS = tspg_pkg::AXES * POSITION_BITS + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [ITEM_BITS-1:0]             item,
	input  logic                             period_we,
	input  logic [tspg_pkg::PERIOD_BITS-1:0] period_wdata,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [tspg_pkg::M_DATA_BITS-1:0] res_data
);

	localparam int P = POSITION_BITS;
	localparam int NA = tspg_pkg::AXES;

	logic [tspg_pkg::PERIOD_BITS-1:0] step_period_q;
	logic signed [P-1:0]              pos_q   [NA];
	logic signed [P-1:0]              goal_q  [NA];
	logic [P:0]                       delta_q [NA];
	logic signed [P+1:0]              err_q   [NA];
	logic [P:0]                       major_q;
	logic [P:0]                       steps_q;
	logic [tspg_pkg::PERIOD_BITS-1:0] tick_q;
	logic [NA-1:0]                    dir_q;
	logic                             moving_q;

	logic signed [P-1:0]              pos_n   [NA];
	logic signed [P-1:0]              goal_n  [NA];
	logic [P:0]                       delta_n [NA];
	logic signed [P+1:0]              err_n   [NA];
	logic [P:0]                       major_n;
	logic [P:0]                       steps_n;
	logic [tspg_pkg::PERIOD_BITS-1:0] tick_n;
	logic [NA-1:0]                    dir_n;
	logic                             moving_n;

	logic signed [P-1:0]              tgt   [NA];
	logic [NA-1:0]                    gt;
	logic [P:0]                       dnew  [NA];
	logic signed [P+1:0]              esub  [NA];
	logic signed [P+1:0]              eadd  [NA];
	logic [P:0]                       mx;
	logic [P:0]                       steps_inc;
	logic [tspg_pkg::PERIOD_BITS-1:0] tick_inc;
	logic [tspg_pkg::PERIOD_BITS-1:0] period_eff;
	logic                             step_now;
	logic                             is_move;
	logic                             take;
	tspg_pkg::result_t                res;

	logic                             res_valid_q;
	logic [tspg_pkg::M_DATA_BITS-1:0] res_data_q;

	assign take       = item_valid && (!res_valid_q || res_ready);
	assign item_ready = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;
	assign res_data   = res_data_q;
	assign is_move    = item[ITEM_BITS-1];

	always_comb begin
		logic [P:0] up;
		logic [P:0] dn;
		for (int a = 0; a < NA; a++) begin
			tgt[a]  = item[a*P +: P];
			gt[a]   = tgt[a] > pos_q[a];
			up      = {tgt[a][P-1], tgt[a]} - {pos_q[a][P-1], pos_q[a]};
			dn      = {pos_q[a][P-1], pos_q[a]} - {tgt[a][P-1], tgt[a]};
			dnew[a] = gt[a] ? up : dn;
			esub[a] = err_q[a] - $signed({1'b0, delta_q[a]});
			eadd[a] = esub[a] + $signed({1'b0, major_q});
		end
	end

	always_comb begin
		mx = dnew[0];
		if (dnew[1] > mx) begin
			mx = dnew[1];
		end
		if (dnew[2] > mx) begin
			mx = dnew[2];
		end
	end

	assign tick_inc   = tick_q + 1'b1;
	assign period_eff = (step_period_q == '0) ? tspg_pkg::PERIOD_BITS'(1) : step_period_q;
	assign step_now   = tick_inc >= period_eff;
	assign steps_inc  = steps_q + 1'b1;

	always_comb begin
		res      = '0;
		pos_n    = pos_q;
		goal_n   = goal_q;
		delta_n  = delta_q;
		err_n    = err_q;
		major_n  = major_q;
		steps_n  = steps_q;
		tick_n   = tick_q;
		dir_n    = dir_q;
		moving_n = moving_q;
		if (is_move) begin
			if (!moving_q) begin
				res.accepted = 1'b1;
				dir_n        = gt;
				delta_n      = dnew;
				goal_n       = tgt;
				major_n      = mx;
				steps_n      = '0;
				tick_n       = '0;
				for (int a = 0; a < NA; a++) begin
					err_n[a] = $signed({1'b0, mx >> 1});
				end
				if (mx == '0) begin
					pos_n    = tgt;
					res.done = 1'b1;
				end else begin
					moving_n = 1'b1;
				end
			end
		end else if (moving_q) begin
			tick_n = tick_inc;
			if (step_now) begin
				tick_n = '0;
				for (int a = 0; a < NA; a++) begin
					if (esub[a] < 0) begin
						err_n[a]    = eadd[a];
						res.step[a] = 1'b1;
					end else begin
						err_n[a] = esub[a];
					end
				end
				steps_n = steps_inc;
				if (steps_inc == major_q) begin
					moving_n = 1'b0;
					pos_n    = goal_q;
					res.done = 1'b1;
				end
			end
		end
		res.dir  = dir_n;
		res.busy = moving_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= tspg_pkg::PERIOD_RESET;
		end else if (period_we) begin
			step_period_q <= period_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NA; a++) begin
				pos_q[a]   <= '0;
				goal_q[a]  <= '0;
				delta_q[a] <= '0;
				err_q[a]   <= '0;
			end
			major_q  <= '0;
			steps_q  <= '0;
			tick_q   <= '0;
			dir_q    <= '0;
			moving_q <= 1'b0;
		end else if (take) begin
			pos_q    <= pos_n;
			goal_q   <= goal_n;
			delta_q  <= delta_n;
			err_q    <= err_n;
			major_q  <= major_n;
			steps_q  <= steps_n;
			tick_q   <= tick_n;
			dir_q    <= dir_n;
			moving_q <= moving_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_data_q <= tspg_pkg::M_DATA_BITS'(res);
		end
	end

endmodule

// ----- src/three_axis_step_pulse_generator.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: target_x, target_y, target_z; tuser: kind
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: step x/y/z, dir x/y/z, busy, done, accepted
// config    in   step_period_we                 step_period
//
// One transaction per cycle sustained while m_axis_tready stays high; a result passes
// through the input register, the 2-deep queue and the back-end state update into the output register.
// The back end applies one item per cycle while its output is not stalled: the abs-delta/max
// path for a move and the error add/compare path for a tick are combinational before the state registers.
// Reset clears all position and interpolation state and loads step_period with 700.
// Either side may stall independently; the queue absorbs the difference.
module three_axis_step_pulse_generator #(
	parameter int POSITION_BITS = tspg_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [30:0] target_x, [61:31] target_y, [92:62] target_z, [95:93] zero
	input  logic [tspg_pkg::S_DATA_BITS-1:0] s_axis_tdata,
	// [0] kind
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] step_x, [1] step_y, [2] step_z, [3] dir_x, [4] dir_y, [5] dir_z,
	// [6] busy_res, [7] move_done, [8] accepted, [15:9] zero
	output logic [tspg_pkg::M_DATA_BITS-1:0] m_axis_tdata,
	input  logic                             step_period_we,
	input  logic [tspg_pkg::PERIOD_BITS-1:0] step_period
);

	localparam int ITEM_BITS = tspg_pkg::AXES * POSITION_BITS + 1;

	logic                 fr_valid;
	logic                 fr_ready;
	logic [ITEM_BITS-1:0] fr_item;
	logic                 q_valid;
	logic                 q_ready;
	logic [ITEM_BITS-1:0] q_item;

	tspg_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_kind  (s_axis_tuser),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.out_item (fr_item)
	);

	tspg_queue #(
		.WIDTH(ITEM_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_data  (fr_item),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_item)
	);

	tspg_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (q_valid),
		.item_ready  (q_ready),
		.item        (q_item),
		.period_we   (step_period_we),
		.period_wdata(step_period),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_data    (m_axis_tdata)
	);

endmodule
